@@ design/orst_pkg.sv @@
package orst_pkg;

  typedef enum logic [2:0] {
    REQ_ALLOC    = 3'd0,
    REQ_SETCNT   = 3'd1,
    REQ_COMPLETE = 3'd2,
    REQ_REPLY    = 3'd3,
    REQ_RELEASE  = 3'd4,
    REQ_LOOKUP   = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD      = 2'd2,
    ST_NOTALLOC = 2'd3
  } status_t;

  localparam int unsigned REG_TABLE_SIZE = 0;
  localparam logic [6:0]  TABLE_SIZE_RST = 7'd64;
  localparam int unsigned SCAN_LANES     = 8;

endpackage

@@ design/outstanding_request_slot_table.sv @@
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    in_tuser req_type, in_tdata request fields
// out_     out  out_tvalid/out_tready  out_tuser status, out_tdata result fields
// cfg_     in   APB write/read         table_size at address 0
// Direct answers (range errors, unused types): registered at accept, no table access.
// Table ops: accept, memory read, modify/write back.
// Allocate adds a scan of the free-slot bitmap, 8 slots per step, after first folding
// the search start back into range when it lies at or above the table size.
// Reset clears the allocated bitmap and counters; the slot memory needs no clear.
// A pending result blocks the next accept until out_tready takes it.
module outstanding_request_slot_table #(
  parameter int SLOTS      = 64,
  parameter int MAX_EVENTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // slot[7:0], handle_seq[39:8], event_index[42:40], event_count[46:43],
  // result_code[54:47], zero pad
  input  logic [55:0] in_tdata,
  // req_type[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_slot[5:0], out_seq[37:6], all_done[38], first_result[46:39],
  // used_count[53:47], zero pad
  output logic [55:0] out_tdata,
  // status[1:0]
  output logic [1:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW  = ($clog2(SLOTS + 1) > 8) ? $clog2(SLOTS + 1) : 8;
  localparam int UW  = $clog2(SLOTS + 1);
  localparam int LW  = $clog2(MAX_EVENTS + 1);
  localparam int MW  = 32 + LW + 8;
  localparam int NL  = orst_pkg::SCAN_LANES;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RD, S_MOD} state_t;

  state_t             state_r;
  logic [6:0]         tsize_r;
  logic [IW-1:0]      ss_r;
  logic [31:0]        nseq_r;
  logic [UW-1:0]      used_r;
  logic [SLOTS-1:0]   alloc_r;
  logic [IW-1:0]      addr_r;
  logic [CW-1:0]      ptr_r;
  logic [CW-1:0]      rem_r;
  logic [2:0]         type_r;
  logic [7:0]         slot_r;
  logic [31:0]        hseq_r;
  logic [2:0]         eidx_r;
  logic [3:0]         ecnt_r;
  logic [7:0]         res_r;
  logic [MW-1:0]      mem [SLOTS];
  logic [MW-1:0]      rdata_r;

  logic               out_valid_r;
  logic [1:0]         o_status_r;
  logic [5:0]         o_slot_r;
  logic [31:0]        o_seq_r;
  logic               o_done_r;
  logic [7:0]         o_first_r;

  logic [CW-1:0]      size;
  logic               in_acc;
  logic               slot_bad;
  logic               eidx_bad;
  logic [2:0]         in_type;
  logic [7:0]         in_slot;

  logic [CW-1:0]      ptr_red;
  logic [2*CW-1:0]    mult;
  logic               red_hit;

  logic [CW:0]        cand;
  logic               found;
  logic [IW-1:0]      fidx;
  logic [CW:0]        ptr_adv;

  logic               a_bit;
  logic [31:0]        r_seq;
  logic [LW-1:0]      r_left;
  logic [7:0]         r_res0;
  logic [31:0]        eff_seq;
  logic [LW-1:0]      left_dec;
  logic [LW-1:0]      ecnt_cl;
  logic               we;
  logic [31:0]        w_seq;
  logic [LW-1:0]      w_left;
  logic [7:0]         w_res0;
  logic [1:0]         m_status;
  logic               m_done;
  logic [7:0]         m_first;
  logic               m_set;
  logic               m_clr;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {25'd0, tsize_r};

  assign in_type = in_tuser;
  assign in_slot = in_tdata[7:0];

  always_comb begin
    size = CW'(tsize_r);
    if (tsize_r == 7'd0) size = CW'(1);
    if (CW'(tsize_r) > CW'(SLOTS)) size = CW'(SLOTS);
  end

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_bad  = CW'(in_slot) >= size;
  assign eidx_bad  = int'(in_tdata[42:40]) >= MAX_EVENTS;

  // one step of folding the search start into [0, size)
  always_comb begin
    ptr_red = ptr_r;
    red_hit = 1'b0;
    mult    = '0;
    for (int j = CW - 1; j >= 0; j--) begin
      mult = (2*CW)'(size) << j;
      if (!red_hit && mult <= (2*CW)'(ptr_r)) begin
        red_hit = 1'b1;
        ptr_red = ptr_r - mult[CW-1:0];
      end
    end
  end

  always_comb begin
    found = 1'b0;
    fidx  = '0;
    cand  = '0;
    for (int k = 0; k < NL; k++) begin
      cand = {1'b0, ptr_r} + (CW + 1)'(k);
      if (cand >= {1'b0, size}) cand = cand - {1'b0, size};
      if (!found && (CW'(k) < rem_r) && !alloc_r[cand[IW-1:0]]) begin
        found = 1'b1;
        fidx  = cand[IW-1:0];
      end
    end
    ptr_adv = {1'b0, ptr_r} + (CW + 1)'(NL);
    if (ptr_adv >= {1'b0, size}) ptr_adv = ptr_adv - {1'b0, size};
  end

  assign a_bit   = alloc_r[addr_r];
  assign r_seq   = rdata_r[MW-1 -: 32];
  assign r_left  = rdata_r[8 +: LW];
  assign r_res0  = rdata_r[7:0];
  assign eff_seq = a_bit ? r_seq : 32'd0;

  always_comb begin
    ecnt_cl = LW'(ecnt_r);
    if (ecnt_r == 4'd0) ecnt_cl = LW'(1);
    if (int'(ecnt_r) > MAX_EVENTS) ecnt_cl = LW'(MAX_EVENTS);
    left_dec = (r_left != '0) ? r_left - LW'(1) : r_left;
  end

  always_comb begin
    we       = 1'b0;
    w_seq    = r_seq;
    w_left   = r_left;
    w_res0   = r_res0;
    m_status = orst_pkg::ST_OK;
    m_done   = 1'b0;
    m_first  = 8'd0;
    m_set    = 1'b0;
    m_clr    = 1'b0;
    case (type_r)
      orst_pkg::REQ_ALLOC: begin
        we     = 1'b1;
        m_set  = 1'b1;
        w_seq  = nseq_r;
        w_left = LW'(1);
      end
      orst_pkg::REQ_SETCNT: begin
        if (!a_bit) begin
          m_status = orst_pkg::ST_NOTALLOC;
        end else begin
          we     = 1'b1;
          w_left = ecnt_cl;
          w_res0 = 8'd0;
        end
      end
      orst_pkg::REQ_COMPLETE: begin
        if (!a_bit) begin
          m_status = orst_pkg::ST_NOTALLOC;
        end else begin
          we = 1'b1;
          if (eidx_r == 3'd0) w_res0 = res_r;
          w_left = left_dec;
          if (left_dec == '0) begin
            m_done = 1'b1;
            w_left = LW'(1);
          end
          m_first = w_res0;
        end
      end
      orst_pkg::REQ_REPLY, orst_pkg::REQ_LOOKUP: begin
        if (eff_seq != hseq_r) begin
          m_status = orst_pkg::ST_BAD;
        end else if (!a_bit) begin
          m_status = orst_pkg::ST_NOTALLOC;
        end else if (type_r == orst_pkg::REQ_REPLY) begin
          we      = 1'b1;
          w_res0  = res_r;
          w_seq   = 32'd0;
          m_first = res_r;
        end
      end
      orst_pkg::REQ_RELEASE: begin
        if (!a_bit) m_status = orst_pkg::ST_NOTALLOC;
        else m_clr = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RD) rdata_r <= mem[addr_r];
    if (state_r == S_MOD && we) mem[addr_r] <= {w_seq, w_left, w_res0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tsize_r     <= orst_pkg::TABLE_SIZE_RST;
      ss_r        <= '0;
      nseq_r      <= '0;
      used_r      <= '0;
      alloc_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == 1'(orst_pkg::REG_TABLE_SIZE)) begin
        tsize_r <= cfg_pwdata[6:0];
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            type_r <= in_type;
            slot_r <= in_slot;
            hseq_r <= in_tdata[39:8];
            eidx_r <= in_tdata[42:40];
            ecnt_r <= in_tdata[46:43];
            res_r  <= in_tdata[54:47];
            addr_r <= in_slot[IW-1:0];
            if (in_type == orst_pkg::REQ_ALLOC) begin
              ptr_r   <= CW'(ss_r) + CW'(1);
              rem_r   <= size;
              state_r <= S_SCAN;
            end else if (in_type > orst_pkg::REQ_LOOKUP) begin
              out_valid_r <= 1'b1;
              o_status_r  <= orst_pkg::ST_OK;
              o_slot_r    <= 6'd0;
              o_seq_r     <= 32'd0;
              o_done_r    <= 1'b0;
              o_first_r   <= 8'd0;
            end else if (slot_bad ||
                         (in_type == orst_pkg::REQ_COMPLETE && eidx_bad)) begin
              out_valid_r <= 1'b1;
              o_status_r  <= orst_pkg::ST_BAD;
              o_slot_r    <= in_slot[5:0];
              o_seq_r     <= 32'd0;
              o_done_r    <= 1'b0;
              o_first_r   <= 8'd0;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_SCAN: begin
          if (ptr_r >= size) begin
            ptr_r <= ptr_red;
          end else begin
            if (rem_r == size) ss_r <= ptr_r[IW-1:0];
            if (found) begin
              addr_r  <= fidx;
              state_r <= S_RD;
            end else if (rem_r <= CW'(NL)) begin
              out_valid_r <= 1'b1;
              o_status_r  <= orst_pkg::ST_FULL;
              o_slot_r    <= 6'd0;
              o_seq_r     <= 32'd0;
              o_done_r    <= 1'b0;
              o_first_r   <= 8'd0;
              state_r     <= S_IDLE;
            end else begin
              ptr_r <= ptr_adv[CW-1:0];
              rem_r <= rem_r - CW'(NL);
            end
          end
        end
        S_RD: state_r <= S_MOD;
        S_MOD: begin
          if (m_set) begin
            alloc_r[addr_r] <= 1'b1;
            used_r          <= used_r + UW'(1);
            nseq_r          <= nseq_r + 32'd1;
          end
          if (m_clr) begin
            alloc_r[addr_r] <= 1'b0;
            if (used_r != '0) used_r <= used_r - UW'(1);
          end
          out_valid_r <= 1'b1;
          o_status_r  <= m_status;
          o_slot_r    <= (type_r == orst_pkg::REQ_ALLOC) ? 6'(addr_r) : slot_r[5:0];
          o_seq_r     <= (type_r == orst_pkg::REQ_ALLOC) ? nseq_r : 32'd0;
          o_done_r    <= m_done;
          o_first_r   <= m_first;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = {2'd0, 7'(used_r), o_first_r, o_done_r, o_seq_r, o_slot_r};

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(SLOTS))
    else $error("used count above slot count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (!out_valid_r || out_tready))
    else $error("accept while result pending");

  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD && m_set) |=> used_r == $past(used_r) + UW'(1))
    else $error("allocate did not bump used count");

  a_scan_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && found) |-> !alloc_r[fidx])
    else $error("scan picked allocated slot");

endmodule

@@ tb/outstanding_request_slot_table_tb.sv @@
module outstanding_request_slot_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 64;
  localparam int NEV = 8;
  localparam logic [2:0] REQ_UNUSED6 = 3'd6;
  localparam logic [2:0] REQ_UNUSED7 = 3'd7;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  slot;
    logic [31:0] hseq;
    logic [2:0]  eidx;
    logic [3:0]  ecnt;
    logic [7:0]  res;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [31:0] seq;
    logic        done;
    logic [7:0]  first;
    logic [6:0]  used;
  } answer_t;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0;
  logic [55:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic in_tready, out_tvalid;
  logic [55:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0, cfg_paddr = 0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  outstanding_request_slot_table DUT (.*);

  // shadow of the table
  logic [6:0]  tsize_reg;
  logic        alloc_q[NSLOT];
  logic [31:0] seq_q[NSLOT];
  logic [3:0]  left_q[NSLOT];
  logic [7:0]  evres_q[NSLOT*NEV];
  logic        ev0_written[NSLOT];
  logic [5:0]  search_q;
  logic [31:0] seq_ctr;
  logic [6:0]  used_q;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int idle_pct = 0, stall_pct = 0;
  int errors = 0;
  int cycles = 0;

  initial forever #6 clk = ~clk;

  function automatic int eff_size();
    if (tsize_reg == 0) return 1;
    if (tsize_reg > NSLOT) return NSLOT;
    return tsize_reg;
  endfunction

  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    int sz, no, cnt;
    bit found;
    a = '0;
    sz = eff_size();
    found = 0;
    if (r.kind == orst_pkg::REQ_ALLOC) begin
      search_q = 6'((search_q + 1) % sz);
      no = search_q;
      for (int i = 0; i < sz; i++) begin
        if (!alloc_q[no]) begin
          found = 1;
          break;
        end
        no = (no + 1) % sz;
      end
      if (!found) a.status = orst_pkg::ST_FULL;
      else begin
        alloc_q[no] = 1;
        used_q++;
        seq_q[no] = seq_ctr;
        a.seq = seq_ctr;
        seq_ctr++;
        left_q[no] = 1;
        a.slot = 6'(no);
      end
    end else if (r.kind <= orst_pkg::REQ_LOOKUP) begin
      a.slot = r.slot[5:0];
      if (r.slot >= sz) a.status = orst_pkg::ST_BAD;
      else if (r.kind == orst_pkg::REQ_SETCNT) begin
        if (!alloc_q[r.slot]) a.status = orst_pkg::ST_NOTALLOC;
        else begin
          cnt = (r.ecnt == 0) ? 1 : (r.ecnt > NEV) ? NEV : r.ecnt;
          left_q[r.slot] = 4'(cnt);
          for (int i = 0; i < cnt; i++) evres_q[r.slot*NEV+i] = 0;
          ev0_written[r.slot] = 1;
        end
      end else if (r.kind == orst_pkg::REQ_COMPLETE) begin
        if (!alloc_q[r.slot]) a.status = orst_pkg::ST_NOTALLOC;
        else begin
          evres_q[r.slot*NEV+r.eidx] = r.res;
          if (r.eidx == 0) ev0_written[r.slot] = 1;
          if (left_q[r.slot] > 0) left_q[r.slot]--;
          if (left_q[r.slot] == 0) begin
            a.done = 1;
            left_q[r.slot] = 1;
          end
          a.first = evres_q[r.slot*NEV];
        end
      end else if (r.kind == orst_pkg::REQ_REPLY || r.kind == orst_pkg::REQ_LOOKUP) begin
        if (seq_q[r.slot] != r.hseq) a.status = orst_pkg::ST_BAD;
        else if (!alloc_q[r.slot]) a.status = orst_pkg::ST_NOTALLOC;
        else if (r.kind == orst_pkg::REQ_REPLY) begin
          evres_q[r.slot*NEV] = r.res;
          ev0_written[r.slot] = 1;
          seq_q[r.slot] = 0;
          a.first = r.res;
        end
      end else begin
        if (!alloc_q[r.slot]) a.status = orst_pkg::ST_NOTALLOC;
        else begin
          alloc_q[r.slot] = 0;
          seq_q[r.slot] = 0;
          if (used_q > 0) used_q--;
        end
      end
    end
    a.used = used_q;
    return a;
  endfunction

  // never ask for event 0's result before it was written
  task automatic issue(request_t r);
    if (r.kind == orst_pkg::REQ_COMPLETE && r.slot < eff_size() && alloc_q[r.slot]
        && !ev0_written[r.slot])
      r.eidx = 0;
    expected_answers.push_back(predict_answer(r));
    pending_reqs.push_back(r);
  endtask

  task automatic req(logic [2:0] k, logic [7:0] s, logic [31:0] h,
                     logic [2:0] e, logic [3:0] c, logic [7:0] rc);
    request_t r;
    r = '{kind: k, slot: s, hseq: h, eidx: e, ecnt: c, res: rc};
    issue(r);
  endtask

  task automatic random_req();
    request_t r;
    int live[$];
    int pick;
    for (int i = 0; i < eff_size(); i++) if (alloc_q[i]) live.push_back(i);
    r.eidx = $urandom_range(7);
    r.ecnt = $urandom_range(15);
    r.res = $urandom_range(255);
    pick = $urandom_range(99);
    if (live.size() > 0 && $urandom_range(9) < 8) begin
      r.slot = live[$urandom_range(live.size()-1)];
      r.hseq = ($urandom_range(9) < 8) ? seq_q[r.slot] : $urandom;
    end else begin
      r.slot = ($urandom_range(1)) ? $urandom_range(255) : $urandom_range(eff_size());
      r.hseq = ($urandom_range(1)) ? $urandom : 32'd0;
    end
    if (pick < 25) r.kind = orst_pkg::REQ_ALLOC;
    else if (pick < 35) r.kind = orst_pkg::REQ_SETCNT;
    else if (pick < 58) r.kind = orst_pkg::REQ_COMPLETE;
    else if (pick < 72) r.kind = orst_pkg::REQ_REPLY;
    else if (pick < 84) r.kind = orst_pkg::REQ_RELEASE;
    else if (pick < 96) r.kind = orst_pkg::REQ_LOOKUP;
    else r.kind = ($urandom_range(1)) ? REQ_UNUSED6 : REQ_UNUSED7;
    issue(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() || in_tvalid || expected_answers.size())
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_table_size(logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= 0; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    tsize_reg = v[6:0];
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) in_tvalid <= 0;
    else if (!in_tvalid || in_tready) begin
      if (pending_reqs.size() && $urandom_range(99) >= idle_pct) begin
        request_t r;
        r = pending_reqs.pop_front();
        in_tuser <= r.kind;
        in_tdata <= {1'b0, r.res, r.ecnt, r.eidx, r.hseq, r.slot};
        in_tvalid <= 1;
      end else in_tvalid <= 0;
    end
  end

  always @(posedge clk)
    out_tready <= rst_n && ($urandom_range(99) >= stall_pct);

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      answer_t got, want;
      got = {out_tuser, out_tdata[5:0], out_tdata[37:6], out_tdata[38],
             out_tdata[46:39], out_tdata[53:47]};
      if (expected_answers.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction: got %h", $time, got);
      end else begin
        want = expected_answers.pop_front();
        if (got.status != want.status || got.slot != want.slot || got.seq != want.seq
            || got.done != want.done || got.first != want.first
            || got.used != want.used) begin
          errors++;
          $display("%0t mismatch: expected st=%0d slot=%0d seq=%h done=%0d first=%h used=%0d",
                   $time, want.status, want.slot, want.seq, want.done, want.first,
                   want.used);
          $display("%0t           actual st=%0d slot=%0d seq=%h done=%0d first=%h used=%0d",
                   $time, got.status, got.slot, got.seq, got.done, got.first, got.used);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int sizes[4] = '{64, 3, 127, 0};
    int idles[4] = '{0, 64, 0, 28};
    int stalls[4] = '{0, 0, 64, 28};
    tsize_reg = orst_pkg::TABLE_SIZE_RST;
    for (int i = 0; i < NSLOT; i++) begin
      alloc_q[i] = 0; seq_q[i] = 0; left_q[i] = 1; ev0_written[i] = 0;
    end
    for (int i = 0; i < NSLOT*NEV; i++) evres_q[i] = 0;
    search_q = 0; seq_ctr = 0; used_q = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    repeat (2) @(posedge clk);

    write_table_size(2);
    req(orst_pkg::REQ_ALLOC, 0, 0, 0, 0, 0);
    req(orst_pkg::REQ_ALLOC, 0, 0, 0, 0, 0);
    req(orst_pkg::REQ_ALLOC, 0, 0, 0, 0, 0);
    req(orst_pkg::REQ_SETCNT, 0, 0, 0, 4'd0, 0);
    req(orst_pkg::REQ_SETCNT, 1, 0, 0, 4'd15, 0);
    req(orst_pkg::REQ_COMPLETE, 1, 0, 3'd7, 0, 8'hff);
    req(orst_pkg::REQ_COMPLETE, 0, 0, 3'd0, 0, 8'h5a);
    req(orst_pkg::REQ_COMPLETE, 1, 0, 3'd3, 0, 8'h00);
    req(orst_pkg::REQ_LOOKUP, 0, 32'hffffffff, 0, 0, 0);
    req(orst_pkg::REQ_LOOKUP, 1, seq_q[1], 0, 0, 0);
    req(orst_pkg::REQ_REPLY, 1, seq_q[1], 0, 0, 8'ha5);
    req(orst_pkg::REQ_REPLY, 1, 32'd1, 0, 0, 8'h11);
    req(orst_pkg::REQ_REPLY, 1, 32'd0, 0, 0, 8'hff);
    req(orst_pkg::REQ_COMPLETE, 8'd255, 0, 0, 0, 0);
    req(orst_pkg::REQ_SETCNT, 8'd2, 0, 0, 4'd8, 0);
    req(orst_pkg::REQ_RELEASE, 0, 0, 0, 0, 0);
    req(orst_pkg::REQ_RELEASE, 0, 0, 0, 0, 0);
    req(orst_pkg::REQ_SETCNT, 0, 0, 0, 4'd1, 0);
    req(orst_pkg::REQ_COMPLETE, 0, 0, 3'd2, 0, 0);
    req(orst_pkg::REQ_LOOKUP, 0, 32'd0, 0, 0, 0);
    req(REQ_UNUSED6, 8'hff, 32'hffffffff, 3'd7, 4'd15, 8'hff);
    req(REQ_UNUSED7, 0, 0, 0, 0, 0);
    req(orst_pkg::REQ_ALLOC, 0, 0, 0, 0, 0);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_table_size(sizes[p]);
      idle_pct = idles[p];
      stall_pct = stalls[p];
      for (int n = 0; n < 120; n++) begin
        if (p == 1 && n == 60) drain();
        random_req();
        while (pending_reqs.size() > 4) @(posedge clk);
      end
      drain();
    end
    idle_pct = 0;
    stall_pct = 0;
    write_table_size(1);
    for (int n = 0; n < 20; n++) random_req();
    drain();

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
